### sv/bps_pkg.sv
// types and constants shared by the best-path selection block
// no dependencies; imported by every module of the block except bps_fifo
`default_nettype none

package bps_pkg;

    localparam int ADDR_BITS = 32;
    localparam int ETX_BITS  = 24;
    localparam int HOP_BITS  = 8;
    localparam int THR_BITS  = 9;

    localparam logic [THR_BITS-1:0] THR_RESET = 9'd256;
    localparam logic [ETX_BITS-1:0] ETX_MAX   = {ETX_BITS{1'b1}};

    localparam logic CMD_PATH     = 1'b0;
    localparam logic CMD_WITHDRAW = 1'b1;

    typedef struct packed {
        logic                 cmd;
        logic [ADDR_BITS-1:0] originator;
        logic [ETX_BITS-1:0]  etx;
        logic [HOP_BITS-1:0]  hops;
        logic                 default_route;
        logic                 last;
    } bps_in_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] best_originator;
        logic [ETX_BITS-1:0]  best_etx;
        logic [HOP_BITS-1:0]  best_hops;
        logic                 gateway_changed;
    } bps_out_t;

    // classified item as it waits between front and back
    typedef struct packed {
        logic                 cmd;
        logic [ADDR_BITS-1:0] originator;
        logic [ETX_BITS-1:0]  etx;
        logic [ETX_BITS-1:0]  scaled_etx;
        logic [HOP_BITS-1:0]  hops;
        logic                 default_route;
        logic                 last;
    } bps_work_t;

endpackage

`default_nettype wire

### sv/bps_fifo.sv
// small register-based fifo used for the work queue and the result queue of the block
// no package dependencies
`default_nettype none

module bps_fifo #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

### sv/bps_front.sv
// front stage: takes input items, holds the threshold register and
// precomputes the gateway-scaled etx; depends on bps_pkg
`default_nettype none

module bps_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire bps_pkg::bps_in_t             in_item,
    input  wire logic                         cfg_valid,
    input  wire logic [bps_pkg::THR_BITS-1:0] cfg_data,
    output logic                              work_valid,
    output bps_pkg::bps_work_t                work_item,
    input  wire logic                         work_full
);

    import bps_pkg::*;

    localparam int PROD_W = ETX_BITS + THR_BITS;

    logic [THR_BITS-1:0] thr_reg;
    logic                valid_reg, valid_next;
    bps_work_t           item_reg;
    logic [PROD_W-1:0]   prod;
    logic [ETX_BITS-1:0] scaled;
    logic                accept;
    logic                sent;

    // scaling is done for every path; the back stage decides whether it applies
    assign prod   = PROD_W'(in_item.etx) * PROD_W'(thr_reg);
    assign scaled = (prod[PROD_W-1:ETX_BITS+8] != '0) ? ETX_MAX : prod[ETX_BITS+7:8];

    assign sent       = valid_reg && !work_full;
    assign full       = valid_reg && work_full;
    assign accept     = push && !full;
    assign work_valid = valid_reg;
    assign work_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (sent)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            thr_reg   <= THR_RESET;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_valid)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.cmd           <= in_item.cmd;
            item_reg.originator    <= in_item.originator;
            item_reg.etx           <= in_item.etx;
            item_reg.scaled_etx    <= scaled;
            item_reg.hops          <= in_item.hops;
            item_reg.default_route <= in_item.default_route;
            item_reg.last          <= in_item.last;
        end
    end

endmodule

`default_nettype wire

### sv/bps_back.sv
// back stage: running best of a run, gateway memory and withdraw handling
// depends on bps_pkg
`default_nettype none

module bps_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               work_valid,
    input  wire bps_pkg::bps_work_t work_item,
    output logic                    work_pop,
    output logic                    res_push,
    output bps_pkg::bps_out_t       res_item,
    input  wire logic               res_full
);

    import bps_pkg::*;

    logic                 run_active_reg, run_active_next;
    logic [ADDR_BITS-1:0] best_id_reg, best_id_next;
    logic [ETX_BITS-1:0]  best_scaled_reg, best_scaled_next;
    logic [ETX_BITS-1:0]  best_raw_reg, best_raw_next;
    logic [HOP_BITS-1:0]  best_hops_reg, best_hops_next;
    logic                 gw_valid_reg, gw_valid_next;
    logic [ADDR_BITS-1:0] gw_id_reg, gw_id_next;

    logic                 is_path;
    logic                 closes_run;
    logic                 go;
    logic                 gw_match;
    logic [ETX_BITS-1:0]  eff_etx;
    logic                 beats;
    logic                 take;
    logic                 changed;

    assign is_path    = (work_item.cmd == CMD_PATH);
    assign closes_run = is_path && work_item.last;
    // only a run close needs room in the result queue
    assign go         = work_valid && (!closes_run || !res_full);
    assign work_pop   = go;
    assign res_push   = go && closes_run;

    assign gw_match = gw_valid_reg && (work_item.originator == gw_id_reg);
    assign eff_etx  = (gw_match && work_item.default_route) ? work_item.scaled_etx
                                                            : work_item.etx;

    // lower etx, then fewer hops, then smaller originator
    assign beats = (eff_etx < best_scaled_reg)
                || ((eff_etx == best_scaled_reg)
                    && ((work_item.hops < best_hops_reg)
                        || ((work_item.hops == best_hops_reg)
                            && (work_item.originator < best_id_reg))));
    assign take  = !run_active_reg || beats;

    always_comb
    begin
        best_id_next     = take ? work_item.originator : best_id_reg;
        best_scaled_next = take ? eff_etx : best_scaled_reg;
        best_raw_next    = take ? work_item.etx : best_raw_reg;
        best_hops_next   = take ? work_item.hops : best_hops_reg;
        run_active_next  = run_active_reg;
        gw_valid_next    = gw_valid_reg;
        gw_id_next       = gw_id_reg;
        changed          = 1'b0;
        if (is_path)
        begin
            run_active_next = !work_item.last;
            if (work_item.last && work_item.default_route)
            begin
                changed       = !gw_valid_reg || (gw_id_reg != best_id_next);
                gw_valid_next = 1'b1;
                gw_id_next    = best_id_next;
            end
        end
        else if (gw_match)
        begin
            gw_valid_next = 1'b0;
            gw_id_next    = '0;
        end
    end

    assign res_item.best_originator = best_id_next;
    assign res_item.best_etx        = best_raw_next;
    assign res_item.best_hops       = best_hops_next;
    assign res_item.gateway_changed = changed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_active_reg  <= 1'b0;
            best_id_reg     <= '0;
            best_scaled_reg <= '0;
            best_raw_reg    <= '0;
            best_hops_reg   <= '0;
            gw_valid_reg    <= 1'b0;
            gw_id_reg       <= '0;
        end
        else if (go)
        begin
            run_active_reg <= run_active_next;
            gw_valid_reg   <= gw_valid_next;
            gw_id_reg      <= gw_id_next;
            if (is_path)
            begin
                best_id_reg     <= best_id_next;
                best_scaled_reg <= best_scaled_next;
                best_raw_reg    <= best_raw_next;
                best_hops_reg   <= best_hops_next;
            end
        end
    end

endmodule

`default_nettype wire

### sv/best_path_select_with_gateway_hysteresis.sv
// top level of the best-path selection block with gateway hysteresis
// depends on bps_pkg, bps_fifo, bps_front and bps_back
//
//  channel   handshake          payload
//  input     push / full        in_item  (bps_in_t)
//  result    pop / empty        result   (bps_out_t)
//  config    cfg_valid / ready  cfg_data (nat_threshold, 9 bits)
//
// one item per cycle while full is low; a result shows on the result ports once its
// closing item is taken and has been written, in turn, into the front register,
// the work queue and the result queue
// the front multiplier and the back compare chain are combinational
// full rises only when the front register and work queue are both occupied
// reset: threshold 1.0, no gateway, no run open, all queues empty
`default_nettype none

module best_path_select_with_gateway_hysteresis #(
    parameter int QUEUE_DEPTH  = 2,
    parameter int RESULT_DEPTH = 2
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire bps_pkg::bps_in_t             in_item,
    input  wire logic                         pop,
    output logic                              empty,
    output bps_pkg::bps_out_t                 result,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [bps_pkg::THR_BITS-1:0] cfg_data
);

    import bps_pkg::*;

    logic      work_valid;
    bps_work_t work_wr;
    logic      q_full;
    logic      q_empty;
    bps_work_t q_rd;
    logic      q_pop;
    logic      res_push;
    bps_out_t  res_item;
    logic      res_full;
    logic      q_push;

    assign cfg_ready = 1'b1;
    assign q_push    = work_valid && !q_full;

    bps_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_item    (in_item),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .work_valid (work_valid),
        .work_item  (work_wr),
        .work_full  (q_full)
    );

    bps_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(bps_work_t))
    ) u_work_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (work_wr),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd),
        .empty   (q_empty)
    );

    bps_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_valid (!q_empty),
        .work_item  (q_rd),
        .work_pop   (q_pop),
        .res_push   (res_push),
        .res_item   (res_item),
        .res_full   (res_full)
    );

    bps_fifo #(
        .DEPTH (RESULT_DEPTH),
        .WIDTH ($bits(bps_out_t))
    ) u_result_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_item),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

    // a result is never dropped at the result queue
    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result written into a full queue");

    // only a closing path item makes a result, and it is consumed with it
    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (q_pop && q_rd.cmd == CMD_PATH && q_rd.last))
        else $error("result without a closing path item");

    // back never pops an empty work queue
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("work queue popped while empty");

    // input stalls only while the work queue is full
    a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> q_full)
        else $error("input stalled with room in the work queue");

endmodule

`default_nettype wire

### bench/testbench.sv
// self-checking bench for best_path_select_with_gateway_hysteresis
// needs bps_pkg and the block's rtl; predicts the selected route of each closed run
`timescale 1ns / 100ps

module testbench;

    import bps_pkg::*;

    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_CYCLES  = 300;
    localparam int PHASE_ITEMS   = 214;
    localparam int CYCLE_LIMIT   = 200000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    bps_in_t             in_item = '0;
    logic                pop = 1'b0;
    logic                empty;
    bps_out_t            result;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [THR_BITS-1:0] cfg_data = '0;

    // predictor state
    logic [THR_BITS-1:0]  gw_scale = THR_RESET;
    logic                 run_open = 1'b0;
    logic [ADDR_BITS-1:0] best_orig = '0;
    logic [ETX_BITS-1:0]  best_scaled = '0;
    logic [ETX_BITS-1:0]  best_raw = '0;
    logic [HOP_BITS-1:0]  best_hop_cnt = '0;
    logic                 gw_valid = 1'b0;
    logic [ADDR_BITS-1:0] gw_id = '0;

    bps_in_t  pending_items[$];
    bps_out_t expected_best[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic        rx_hold = 1'b0;
    logic        pressure_go = 1'b0;
    int          fail_count = 0;
    int unsigned cycle_count = 0;

    best_path_select_with_gateway_hysteresis u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .pop       (pop),
        .empty     (empty),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void route_select_step(input bps_in_t it);
        logic [ETX_BITS+THR_BITS-1:0] product;
        logic [ETX_BITS-1:0]          eff_etx;
        logic                         wins;
        bps_out_t                     res;
        if (it.cmd == CMD_WITHDRAW)
        begin
            if (gw_valid && it.originator == gw_id)
            begin
                gw_valid = 1'b0;
                gw_id    = '0;
            end
            return;
        end
        product = it.etx * gw_scale;
        eff_etx = it.etx;
        // hysteresis: only the remembered gateway's default route is scaled
        if (gw_valid && it.default_route && it.originator == gw_id)
            eff_etx = ((product >> 8) > ETX_MAX) ? ETX_MAX : ETX_BITS'(product >> 8);
        wins = !run_open || eff_etx < best_scaled ||
               (eff_etx == best_scaled && (it.hops < best_hop_cnt ||
               (it.hops == best_hop_cnt && it.originator < best_orig)));
        if (wins)
        begin
            best_orig    = it.originator;
            best_scaled  = eff_etx;
            best_raw     = it.etx;
            best_hop_cnt = it.hops;
        end
        if (!it.last)
        begin
            run_open = 1'b1;
            return;
        end
        run_open = 1'b0;
        res.best_originator = best_orig;
        res.best_etx        = best_raw;
        res.best_hops       = best_hop_cnt;
        res.gateway_changed = 1'b0;
        if (it.default_route)
        begin
            res.gateway_changed = !gw_valid || gw_id != best_orig;
            gw_valid = 1'b1;
            gw_id    = best_orig;
        end
        expected_best.push_back(res);
    endfunction

    // sender side
    always @(negedge clk)
    begin
        if (rst_n && pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
        begin
            push    <= 1'b1;
            in_item <= pending_items[0];
        end
        else
            push <= 1'b0;
    end

    // receiver side
    always @(negedge clk)
    begin
        pop <= rst_n && !rx_hold && $urandom_range(99) >= recv_idle_pct;
    end

    // transfers seen at the rising edge: predict on input, check on output
    always @(posedge clk)
    begin : monitor
        bps_out_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                gw_scale = cfg_data;
            if (push && !full)
            begin
                route_select_step(in_item);
                void'(pending_items.pop_front());
            end
            if (pop && !empty)
            begin
                if (expected_best.size() == 0)
                begin
                    $error("result with no expectation waiting: %h", result);
                    fail_count++;
                end
                else
                begin
                    want = expected_best.pop_front();
                    if (result.best_originator !== want.best_originator)
                    begin
                        $error("best_originator: expected %h, got %h",
                               want.best_originator, result.best_originator);
                        fail_count++;
                    end
                    if (result.best_etx !== want.best_etx)
                    begin
                        $error("best_etx: expected %h, got %h", want.best_etx, result.best_etx);
                        fail_count++;
                    end
                    if (result.best_hops !== want.best_hops)
                    begin
                        $error("best_hops: expected %0d, got %0d",
                               want.best_hops, result.best_hops);
                        fail_count++;
                    end
                    if (result.gateway_changed !== want.gateway_changed)
                    begin
                        $error("gateway_changed: expected %b, got %b",
                               want.gateway_changed, result.gateway_changed);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("best_path_select_with_gateway_hysteresis regression: fail");
            $finish;
        end
    end

    // long receiver hold-off so that the block fills and pushes back on its input
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (STALL_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic queue_path(input logic [ADDR_BITS-1:0] orig, input logic [ETX_BITS-1:0] etx,
                              input logic [HOP_BITS-1:0] hops, input logic dflt,
                              input logic last);
        bps_in_t it;
        it.cmd           = CMD_PATH;
        it.originator    = orig;
        it.etx           = etx;
        it.hops          = hops;
        it.default_route = dflt;
        it.last          = last;
        pending_items.push_back(it);
    endtask

    task automatic queue_withdraw(input logic [ADDR_BITS-1:0] orig);
        bps_in_t it;
        // the remaining fields are don't-care for a withdraw
        it            = '1;
        it.cmd        = CMD_WITHDRAW;
        it.originator = orig;
        pending_items.push_back(it);
    endtask

    function automatic logic [ADDR_BITS-1:0] pick_originator();
        case ($urandom_range(9))
            0: return 32'h0A00_0001;
            1: return 32'h0A00_0002;
            2: return 32'h0A00_0003;
            3: return 32'hC0A8_0001;
            4: return 32'h8000_0000;
            5: return 32'hFFFF_FFFF;
            6: return 32'h0000_0000;
            default: return ADDR_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [ETX_BITS-1:0] pick_etx();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
            return ETX_BITS'($urandom);
        if (r < 15)
            return ETX_MAX - ETX_BITS'($urandom_range(3));
        // coarse grid so that ties on etx are common
        return ETX_BITS'($urandom_range(4, 16) * 64);
    endfunction

    function automatic logic [HOP_BITS-1:0] pick_hops();
        if ($urandom_range(9) == 0)
            return HOP_BITS'($urandom);
        return HOP_BITS'($urandom_range(1, 4));
    endfunction

    // one run, one withdraw or one stray candidate; returns the number of items queued
    function automatic int add_random_group();
        int unsigned pick;
        int unsigned run_len;
        logic        dflt;
        bps_in_t     it;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            it               = '0;
            it.cmd           = CMD_WITHDRAW;
            it.originator    = pick_originator();
            it.etx           = ETX_BITS'($urandom);
            it.hops          = HOP_BITS'($urandom);
            it.default_route = 1'($urandom);
            it.last          = 1'($urandom);
            pending_items.push_back(it);
            return 1;
        end
        if (pick < 12)
        begin
            it.cmd           = CMD_PATH;
            it.originator    = ADDR_BITS'($urandom);
            it.etx           = ETX_BITS'($urandom);
            it.hops          = HOP_BITS'($urandom);
            it.default_route = 1'($urandom);
            it.last          = 1'($urandom);
            pending_items.push_back(it);
            return 1;
        end
        run_len = $urandom_range(1, 6);
        dflt    = $urandom_range(99) < 60;
        for (int k = 0; k < run_len; k++)
        begin
            it.cmd           = CMD_PATH;
            it.originator    = pick_originator();
            it.etx           = pick_etx();
            it.hops          = pick_hops();
            it.default_route = ($urandom_range(19) == 0) ? !dflt : dflt;
            it.last          = (k == run_len - 1);
            pending_items.push_back(it);
        end
        return run_len;
    endfunction

    function automatic logic [THR_BITS-1:0] threshold_for(input int unsigned phase);
        case (phase)
            0: return '0;
            1: return '1;
            2: return 9'd192;
            3: return THR_RESET;
            4: return 9'd1;
            5: return 9'd384;
            6: return 9'd224;
            7: return THR_BITS'($urandom_range(511));
            default: return 9'd255;
        endcase
    endfunction

    task automatic write_threshold(input logic [THR_BITS-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || expected_best.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin : stimulus
        int added;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 38;
        recv_idle_pct = 65;

        // threshold left at its reset value of 1.0
        queue_path(32'h0000_0010, 24'h000100, 8'd3, 1'b0, 1'b1);
        queue_path(32'hFFFF_FFFF, ETX_MAX, 8'hFF, 1'b0, 1'b0);
        queue_path(32'h0000_0000, 24'h000000, 8'd0, 1'b0, 1'b1);
        // equal etx: fewer hops, then the smaller originator
        queue_path(32'h0000_0030, 24'h000200, 8'd5, 1'b0, 1'b0);
        queue_path(32'h0000_0020, 24'h000200, 8'd4, 1'b0, 1'b0);
        queue_path(32'h0000_0010, 24'h000200, 8'd4, 1'b0, 1'b1);
        // exact tie keeps the running best
        queue_path(32'h0000_0030, 24'h000100, 8'd2, 1'b0, 1'b0);
        queue_path(32'h0000_0030, 24'h000100, 8'd2, 1'b0, 1'b1);
        queue_withdraw(32'h0000_0055);
        queue_path(32'h0A00_0001, 24'h000300, 8'd2, 1'b1, 1'b0);
        queue_path(32'h0A00_0002, 24'h000280, 8'd3, 1'b1, 1'b1);
        queue_path(32'h0A00_0002, 24'h000280, 8'd3, 1'b1, 1'b1);
        wait_idle();

        // scaling up saturates the gateway's etx
        write_threshold(9'd511);
        queue_path(32'h0A00_0002, ETX_MAX, 8'd1, 1'b1, 1'b0);
        queue_path(32'h0A00_0003, 24'hFFFFFE, 8'd1, 1'b1, 1'b1);
        wait_idle();

        write_threshold(9'd128);
        // gateway keeps the route despite a worse raw etx
        queue_path(32'h0A00_0003, 24'h000400, 8'd4, 1'b1, 1'b0);
        queue_path(32'h0A00_0004, 24'h000300, 8'd4, 1'b1, 1'b1);
        // gateway withdrawn mid-run: stored best keeps its scaled etx
        queue_path(32'h0A00_0003, 24'h000400, 8'd4, 1'b1, 1'b0);
        queue_withdraw(32'h0A00_0003);
        queue_path(32'h0A00_0004, 24'h000300, 8'd4, 1'b1, 1'b1);
        // mixed flags: the closing item is not a default route
        queue_path(32'h0A00_0003, 24'h000400, 8'd4, 1'b1, 1'b0);
        queue_path(32'h0000_0005, 24'h000300, 8'd4, 1'b0, 1'b1);
        queue_withdraw(32'h0A00_0003);
        wait_idle();

        for (int unsigned phase = 0; phase < 9; phase++)
        begin
            case (phase / 3)
                0:
                begin
                    send_idle_pct = 38;
                    recv_idle_pct = 65;
                end
                1:
                begin
                    send_idle_pct = 65;
                    recv_idle_pct = 38;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_threshold(threshold_for(phase));
            if (phase == 6)
                pressure_go = 1'b1;
            added = 0;
            while (added < PHASE_ITEMS)
                added += add_random_group();
            // close any open run before the next register write
            queue_path(pick_originator(), pick_etx(), pick_hops(), 1'($urandom), 1'b1);
            wait_idle();
        end

        if (fail_count == 0)
            $display("best_path_select_with_gateway_hysteresis regression: pass");
        else
            $display("best_path_select_with_gateway_hysteresis regression: fail");
        $finish;
    end

endmodule
